[rtl/utf16u8_pkg.sv]
// ----------------------------------------------------------------------------
// utf16u8_pkg
// shared types and constants of the utf-16 to utf-8 transcoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utf16u8_pkg;

  // status codes reported on the final beat of a payload
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ODD_COUNT = 3'd1;
  localparam logic [2:0] ST_TRAIL_HI  = 3'd2;
  localparam logic [2:0] ST_BAD_PAIR  = 3'd3;
  localparam logic [2:0] ST_LONE_LO   = 3'd4;

  // surrogate tags on unit bits [15:10]
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // utf-8 range limits and lead / continuation marks
  localparam logic [20:0] LIM_1BYTE = 21'h00007F;
  localparam logic [20:0] LIM_2BYTE = 21'h0007FF;
  localparam logic [20:0] LIM_3BYTE = 21'h00FFFF;
  localparam logic [7:0]  LEAD_2    = 8'hC0;
  localparam logic [7:0]  LEAD_3    = 8'hE0;
  localparam logic [7:0]  LEAD_4    = 8'hF0;
  localparam logic [7:0]  CONT_MARK = 8'h80;

  localparam int QUEUE_DEPTH_DEF = 4;

  // one work entry between front and back
  typedef struct packed {
    logic        is_text;  // 1: encode cp, 0: status-only beat
    logic        eom;
    logic [2:0]  status;
    logic [20:0] cp;
  } op_t;

endpackage

`default_nettype wire

[rtl/utf16u8_front.sv]
// ----------------------------------------------------------------------------
// utf16u8_front
// pairs input bytes into units, joins surrogates, tracks errors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16u8_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_wr_en,
  input  wire                     cfg_wr_data,
  input  wire                     accept,
  input  wire [7:0]               data_byte,
  input  wire                     last_byte,
  output logic                    push,
  output utf16u8_pkg::op_t        push_op
);

  logic        le_mode_r;
  logic        phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        hp_r, hp_nxt;
  logic [9:0]  hbits_r, hbits_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [15:0] unit;
  logic        is_hi, is_lo;
  logic        text_go;
  logic [20:0] cp;

  assign unit  = le_mode_r ? {data_byte, held_r} : {held_r, data_byte};
  assign is_hi = (unit[15:10] == utf16u8_pkg::HI_SURR_TAG);
  assign is_lo = (unit[15:10] == utf16u8_pkg::LO_SURR_TAG);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    hp_nxt    = hp_r;
    hbits_nxt = hbits_r;
    err_nxt   = err_r;
    text_go   = 1'b0;
    cp        = '0;
    push      = 1'b0;
    push_op   = '0;
    if (accept) begin
      if (!phase_r) begin
        held_nxt  = data_byte;
        phase_nxt = 1'b1;
        if (last_byte) begin
          push           = 1'b1;
          push_op.eom    = 1'b1;
          push_op.status = utf16u8_pkg::ST_ODD_COUNT;
        end
      end else begin
        phase_nxt = 1'b0;
        if (err_r == utf16u8_pkg::ST_OK) begin
          if (hp_r) begin
            if (is_lo) begin
              cp      = utf16u8_pkg::SUPP_BASE + {1'b0, hbits_r, unit[9:0]};
              text_go = 1'b1;
              hp_nxt  = 1'b0;
            end else begin
              err_nxt = utf16u8_pkg::ST_BAD_PAIR;
            end
          end else if (is_hi) begin
            if (last_byte) begin
              err_nxt = utf16u8_pkg::ST_TRAIL_HI;
            end else begin
              hp_nxt    = 1'b1;
              hbits_nxt = unit[9:0];
            end
          end else if (is_lo) begin
            err_nxt = utf16u8_pkg::ST_LONE_LO;
          end else begin
            cp      = {5'd0, unit};
            text_go = 1'b1;
          end
        end
        if (last_byte && err_nxt != utf16u8_pkg::ST_OK) begin
          push           = 1'b1;
          push_op.eom    = 1'b1;
          push_op.status = err_nxt;
        end else if (text_go) begin
          push            = 1'b1;
          push_op.is_text = 1'b1;
          push_op.eom     = last_byte;
          push_op.cp      = cp;
        end
      end
      // message end returns the per-payload state to reset
      if (last_byte) begin
        phase_nxt = 1'b0;
        held_nxt  = '0;
        hp_nxt    = 1'b0;
        hbits_nxt = '0;
        err_nxt   = utf16u8_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_mode_r <= 1'b0;
      phase_r   <= 1'b0;
      held_r    <= '0;
      hp_r      <= 1'b0;
      hbits_r   <= '0;
      err_r     <= utf16u8_pkg::ST_OK;
    end else begin
      if (cfg_wr_en) begin
        le_mode_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      hp_r    <= hp_nxt;
      hbits_r <= hbits_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/utf16u8_queue.sv]
// ----------------------------------------------------------------------------
// utf16u8_queue
// small register queue of work entries between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16u8_queue #(
  parameter int DEPTH = utf16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  utf16u8_pkg::op_t        push_op,
  output logic                    full,
  input  wire                     pop,
  output logic                    head_valid,
  output utf16u8_pkg::op_t        head_op
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utf16u8_pkg::op_t store_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/utf16u8_back.sv]
// ----------------------------------------------------------------------------
// utf16u8_back
// utf-8 encoder, one output beat per unstalled cycle into an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16u8_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     head_valid,
  input  utf16u8_pkg::op_t        head_op,
  output logic                    pop,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_byte_valid,
  output logic                    out_end_of_message,
  output logic [2:0]              out_status
);

  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r;
  logic        bvalid_r;
  logic        eom_r;
  logic [2:0]  status_r;
  logic [1:0]  idx_r, idx_nxt;

  logic        load;
  logic [1:0]  last_idx;
  logic [1:0]  grp;
  logic [5:0]  grp_bits;
  logic [7:0]  enc_byte;
  logic        op_done;

  // number of utf-8 bytes minus one
  always_comb begin
    if (!head_op.is_text || head_op.cp <= utf16u8_pkg::LIM_1BYTE) begin
      last_idx = 2'd0;
    end else if (head_op.cp <= utf16u8_pkg::LIM_2BYTE) begin
      last_idx = 2'd1;
    end else if (head_op.cp <= utf16u8_pkg::LIM_3BYTE) begin
      last_idx = 2'd2;
    end else begin
      last_idx = 2'd3;
    end
  end

  assign grp = last_idx - idx_r;

  always_comb begin
    case (grp)
      2'd0:    grp_bits = head_op.cp[5:0];
      2'd1:    grp_bits = head_op.cp[11:6];
      2'd2:    grp_bits = head_op.cp[17:12];
      2'd3:    grp_bits = {3'd0, head_op.cp[20:18]};
      default: grp_bits = '0;
    endcase
  end

  always_comb begin
    if (idx_r != 2'd0) begin
      enc_byte = utf16u8_pkg::CONT_MARK | {2'b00, grp_bits};
    end else begin
      case (last_idx)
        2'd0:    enc_byte = {1'b0, head_op.cp[6:0]};
        2'd1:    enc_byte = utf16u8_pkg::LEAD_2 | {2'b00, grp_bits};
        2'd2:    enc_byte = utf16u8_pkg::LEAD_3 | {2'b00, grp_bits};
        2'd3:    enc_byte = utf16u8_pkg::LEAD_4 | {2'b00, grp_bits};
        default: enc_byte = '0;
      endcase
    end
  end

  assign load    = head_valid && (!valid_r || !out_stall);
  assign op_done = (idx_r == last_idx);
  assign pop     = load && op_done;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = op_done ? 2'd0 : idx_r + 2'd1;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= enc_byte;
      bvalid_r <= head_op.is_text;
      eom_r    <= head_op.eom && op_done;
      status_r <= op_done ? head_op.status : utf16u8_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_byte           = byte_r;
  assign out_byte_valid     = bvalid_r;
  assign out_end_of_message = eom_r;
  assign out_status         = status_r;

endmodule

`default_nettype wire

[rtl/utf16_to_utf8_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// utf-16 byte stream in, utf-8 byte stream out, error status at message end
// ----------------------------------------------------------------------------
// The unit takes one utf-16 payload byte per input beat and can accept a new
// beat every cycle while its work queue has room; the output side gives one
// utf-8 byte per unstalled cycle from an output register. A unit (two input
// beats) yields one to three output beats, a surrogate pair (four input beats)
// four, so with an unstalled consumer the sustained input rate is set by the
// single-byte-per-cycle encoder stage; the QUEUE_DEPTH-entry queue between
// the byte pairing front and the encoder absorbs the bursts. The first error
// of a payload stops text and, unless an odd count outranks it, is reported
// on one status-only beat (byte_valid low) with end_of_message; a good payload
// marks end_of_message on its last text byte with status ok. cfg_wr_data
// selects little endian unit order; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder_unit #(
  parameter int QUEUE_DEPTH = utf16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  // configuration: little endian mode
  input  wire        cfg_wr_en,
  input  wire        cfg_wr_data,
  // input beats
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  in_data_byte,
  input  wire        in_last_byte,
  // output beats
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_message,
  output logic [2:0] out_status
);

  logic             q_full;
  logic             accept;
  logic             push;
  utf16u8_pkg::op_t push_op;
  logic             pop;
  logic             head_valid;
  utf16u8_pkg::op_t head_op;

  // front never pushes more than one entry per beat, so room for one is enough
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // byte pairing, surrogate joining, error tracking
  utf16u8_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .push        (push),
    .push_op     (push_op)
  );

  // decouples the two sides
  utf16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // utf-8 byte serializer with output register
  utf16u8_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_op            (head_op),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_end_of_message (out_end_of_message),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire

[rtl/utf16u8_checker.sv]
// ----------------------------------------------------------------------------
// utf16u8_checker
// port level checks of the transcoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16u8_checker (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       out_valid,
  input  wire       out_stall,
  input  wire [7:0] out_byte,
  input  wire       out_byte_valid,
  input  wire       out_end_of_message,
  input  wire [2:0] out_status
);

  // error status only on the closing beat
  a_status_at_eom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != utf16u8_pkg::ST_OK |-> out_end_of_message)
    else $error("error status before end of message");

  // a status-only beat is a closing error beat with a zero byte
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |->
      out_end_of_message && out_status != utf16u8_pkg::ST_OK && out_byte == 8'd0)
    else $error("malformed status-only beat");

  // text beats never carry an error
  a_text_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_status == utf16u8_pkg::ST_OK)
    else $error("error status on a text beat");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_end_of_message) && $stable(out_status))
    else $error("stalled output beat changed");

endmodule

bind utf16_to_utf8_transcoder_unit utf16u8_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte           (out_byte),
  .out_byte_valid     (out_byte_valid),
  .out_end_of_message (out_end_of_message),
  .out_status         (out_status)
);

`default_nettype wire

[verif/utf16_to_utf8_transcoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_checker
// watches both beat channels and the endian register, predicts the utf-8
// beats of every accepted utf-16 octet and compares them in order
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_wr_en,
  input  wire        cfg_wr_data,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire [7:0]  in_data_byte,
  input  wire        in_last_byte,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire [7:0]  out_byte,
  input  wire        out_byte_valid,
  input  wire        out_end_of_message,
  input  wire [2:0]  out_status,
  output int         beats_pending,
  output int         mismatch_count,
  output int         text_beats,
  output int         status_beats
);

  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [7:0] octet;
    logic       text;
    logic       eom;
    logic [2:0] status;
  } utf8_beat_t;

  utf8_beat_t utf8_due_q[$];

  // shadow of the block state
  logic       le_mode;
  logic       unit_half;
  logic [7:0] held_octet;
  logic       hi_waiting;
  logic [9:0] hi_payload;
  logic [2:0] first_error;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t mismatch on %s: got 0x%h, want 0x%h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_payload();
    unit_half   = 1'b0;
    held_octet  = 8'h00;
    hi_waiting  = 1'b0;
    hi_payload  = 10'd0;
    first_error = utf16u8_pkg::ST_OK;
  endtask

  task automatic push_beat(input logic [7:0] octet, input logic text, input logic eom,
                           input logic [2:0] status);
    utf8_beat_t b;
    b.octet  = octet;
    b.text   = text;
    b.eom    = eom;
    b.status = status;
    utf8_due_q = {utf8_due_q, b};
  endtask

  task automatic push_code_point(input logic [20:0] cp, input logic last);
    logic [7:0] seq [4];
    int n;
    if (cp <= utf16u8_pkg::LIM_1BYTE) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp <= utf16u8_pkg::LIM_2BYTE) begin
      seq[0] = utf16u8_pkg::LEAD_2 | {3'b000, cp[10:6]};
      seq[1] = utf16u8_pkg::CONT_MARK | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp <= utf16u8_pkg::LIM_3BYTE) begin
      seq[0] = utf16u8_pkg::LEAD_3 | {4'b0000, cp[15:12]};
      seq[1] = utf16u8_pkg::CONT_MARK | {2'b00, cp[11:6]};
      seq[2] = utf16u8_pkg::CONT_MARK | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = utf16u8_pkg::LEAD_4 | {5'b00000, cp[20:18]};
      seq[1] = utf16u8_pkg::CONT_MARK | {2'b00, cp[17:12]};
      seq[2] = utf16u8_pkg::CONT_MARK | {2'b00, cp[11:6]};
      seq[3] = utf16u8_pkg::CONT_MARK | {2'b00, cp[5:0]};
      n = 4;
    end
    // a good payload flags its end on the last text octet
    for (int i = 0; i < n; i++)
      push_beat(seq[i], 1'b1, last && (i == n - 1), utf16u8_pkg::ST_OK);
  endtask

  task automatic transcode_octet(input logic [7:0] octet, input logic last);
    logic [15:0] unit;
    logic [20:0] cp;
    logic        emit;
    emit = 1'b0;
    cp   = '0;
    if (!unit_half) begin
      held_octet = octet;
      unit_half  = 1'b1;
      // odd count outranks any latched error
      if (last) begin
        push_beat(8'h00, 1'b0, 1'b1, utf16u8_pkg::ST_ODD_COUNT);
        clear_payload();
      end
    end else begin
      unit_half = 1'b0;
      if (first_error == utf16u8_pkg::ST_OK) begin
        unit = le_mode ? {octet, held_octet} : {held_octet, octet};
        if (hi_waiting) begin
          if (unit[15:10] == utf16u8_pkg::LO_SURR_TAG) begin
            cp = utf16u8_pkg::SUPP_BASE + {1'b0, hi_payload, unit[9:0]};
            hi_waiting = 1'b0;
            emit = 1'b1;
          end else begin
            first_error = utf16u8_pkg::ST_BAD_PAIR;
          end
        end else if (unit[15:10] == utf16u8_pkg::HI_SURR_TAG) begin
          if (last) begin
            first_error = utf16u8_pkg::ST_TRAIL_HI;
          end else begin
            hi_waiting = 1'b1;
            hi_payload = unit[9:0];
          end
        end else if (unit[15:10] == utf16u8_pkg::LO_SURR_TAG) begin
          first_error = utf16u8_pkg::ST_LONE_LO;
        end else begin
          cp = {5'd0, unit};
          emit = 1'b1;
        end
      end
      if (emit)
        push_code_point(cp, last);
      if (last) begin
        if (first_error != utf16u8_pkg::ST_OK)
          push_beat(8'h00, 1'b0, 1'b1, first_error);
        clear_payload();
      end
    end
  endtask

  always @(posedge clk) begin
    utf8_beat_t want;
    if (!rst_n) begin
      le_mode = 1'b0;
      clear_payload();
      utf8_due_q.delete();
      mismatch_count = 0;
      text_beats = 0;
      status_beats = 0;
    end else begin
      if (cfg_wr_en)
        le_mode = cfg_wr_data;
      if (in_valid && !in_stall)
        transcode_octet(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (utf8_due_q.size() == 0) begin
          report_mismatch("beat with no result due", out_byte, 8'h00);
        end else begin
          want = utf8_due_q.pop_front();
          if (want.text)
            text_beats++;
          else
            status_beats++;
          if (out_byte !== want.octet)
            report_mismatch("out_byte", out_byte, want.octet);
          if (out_byte_valid !== want.text)
            report_mismatch("out_byte_valid", 8'(out_byte_valid), 8'(want.text));
          if (out_end_of_message !== want.eom)
            report_mismatch("out_end_of_message", 8'(out_end_of_message),
                            8'(want.eom));
          if (out_status !== want.status)
            report_mismatch("out_status", 8'(out_status), 8'(want.status));
        end
      end
    end
    beats_pending <= utf8_due_q.size();
  end

endmodule

[verif/utf16_to_utf8_transcoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit_test
// drives utf-16 payloads octet by octet in both unit orders, with bursty
// input, random output stalls and one long output hold-off; the checker
// beside the block predicts and compares every utf-8 and status beat
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit_test;

  localparam int SETTLE_CYCLES   = 32;         // block may still hold octets with no beat
  localparam int HOLD_OFF_CYCLES = 250;        // long receiver hold-off
  localparam int PHASE_OCTETS    = 50;         // minimum random octets per endian setting
  localparam int TIMEOUT_NS      = 3_000_000;

  // unit classes for the payload builder
  typedef enum int {U_ASCII, U_TWO, U_THREE, U_HIGH, U_LOW, U_NOT_LOW, U_ANY} unit_class_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_valid;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_stall;
  wire        in_stall;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        out_byte_valid;
  wire        out_end_of_message;
  wire  [2:0] out_status;

  int beats_pending;
  int mismatch_count;
  int text_beats;
  int status_beats;

  bit         hold_off_req = 1'b0;  // raised by stimulus, served by the receiver
  logic       stream_le;            // unit order the payload builder uses
  logic [7:0] payload_q[$];         // octets of the payload being sent
  int         burst_left = 0;
  int         payload_count = 0;
  int         octet_count = 0;
  int         setting_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  utf16_to_utf8_transcoder_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_end_of_message (out_end_of_message),
    .out_status         (out_status)
  );

  utf16_to_utf8_transcoder_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_end_of_message (out_end_of_message),
    .out_status         (out_status),
    .beats_pending      (beats_pending),
    .mismatch_count     (mismatch_count),
    .text_beats         (text_beats),
    .status_beats       (status_beats)
  );

  // draw one 16-bit unit of the given class
  function automatic logic [15:0] pick_unit(input unit_class_t cls);
    logic [15:0] u;
    case (cls)
      U_ASCII: u = 16'($urandom_range(0, 'h7F));
      U_TWO:   u = 16'($urandom_range('h80, 'h7FF));
      U_THREE: begin
        // stay clear of the surrogate block
        if ($urandom_range(0, 1) == 0)
          u = 16'($urandom_range('h800, 'hD7FF));
        else
          u = 16'($urandom_range('hE000, 'hFFFF));
      end
      U_HIGH:  u = 16'($urandom_range('hD800, 'hDBFF));
      U_LOW:   u = 16'($urandom_range('hDC00, 'hDFFF));
      U_NOT_LOW: begin
        // half the time another high surrogate, which also breaks the pair
        if ($urandom_range(0, 1) == 0) begin
          u = 16'($urandom_range('hD800, 'hDBFF));
        end else begin
          do
            u = 16'($urandom_range(0, 'hFFFF));
          while (u[15:10] == utf16u8_pkg::LO_SURR_TAG);
        end
      end
      default: u = 16'($urandom_range(0, 'hFFFF));
    endcase
    return u;
  endfunction

  // split a unit into octets in the current transmission order
  task automatic add_unit(input logic [15:0] u);
    if (stream_le) begin
      payload_q = {payload_q, u[7:0], u[15:8]};
    end else begin
      payload_q = {payload_q, u[15:8], u[7:0]};
    end
  endtask

  // one well-formed character: 1, 2, 3 or 4 utf-8 octets
  task automatic add_char();
    case ($urandom_range(0, 3))
      0: add_unit(pick_unit(U_ASCII));
      1: add_unit(pick_unit(U_TWO));
      2: add_unit(pick_unit(U_THREE));
      default: begin
        add_unit(pick_unit(U_HIGH));
        add_unit(pick_unit(U_LOW));
      end
    endcase
  endtask

  // mostly clean text; the rest odd counts, surrogate faults and noise
  task automatic build_random_payload();
    int shape;
    int fault;
    payload_q.delete();
    shape = $urandom_range(0, 9);
    if (shape == 9) begin
      repeat ($urandom_range(1, 6)) add_unit(pick_unit(U_ANY));
    end else begin
      repeat ($urandom_range(1, 6)) add_char();
      if (shape == 7) begin
        payload_q = {payload_q, 8'($urandom_range(0, 255))};
      end else if (shape == 8) begin
        fault = $urandom_range(0, 2);
        case (fault)
          0: add_unit(pick_unit(U_HIGH));          // high surrogate at the end
          1: begin                                  // high not followed by low
            add_unit(pick_unit(U_HIGH));
            add_unit(pick_unit(U_NOT_LOW));
          end
          default: add_unit(pick_unit(U_LOW));     // low with no high
        endcase
        // text after the fault must stay silent
        if (fault != 0)
          repeat ($urandom_range(0, 3)) add_char();
        if ($urandom_range(0, 2) == 0)
          payload_q = {payload_q, 8'($urandom_range(0, 255))};
      end
    end
  endtask

  // offer the payload beat by beat; steady payloads go without gaps
  task automatic send_payload(input bit steady);
    for (int i = 0; i < payload_q.size(); i++) begin
      if (!steady && burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      in_valid     <= 1'b1;
      in_data_byte <= payload_q[i];
      in_last_byte <= (i == payload_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (burst_left > 0)
        burst_left--;
    end
    payload_count++;
    octet_count += payload_q.size();
  endtask

  // let every predicted beat come out, then allow for octets still inside
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // endian register changes only while the block is idle
  task automatic write_endian(input logic le);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= le;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stream_le = le;
    setting_count++;
  endtask

  // receiver: spans of free flow, light and heavy stalling, plus a long
  // hold-off on request so the block fills and pushes back on its input
  initial begin : receiver
    int mode;
    out_stall <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(8, 60)) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d beats still due", beats_pending);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int phase_octets;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    stream_le = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed payloads in the reset unit order (high octet first)
    // range edges of the one and two octet forms
    payload_q.delete();
    add_unit(16'h0000);
    add_unit(16'h007F);
    add_unit(16'h0080);
    add_unit(16'h07FF);
    send_payload(1'b0);
    // three octet edges, lowest and highest supplementary code points
    payload_q.delete();
    add_unit(16'h0800);
    add_unit(16'hFFFF);
    add_unit(16'hD800);
    add_unit(16'hDC00);
    add_unit(16'hDBFF);
    add_unit(16'hDFFF);
    send_payload(1'b1);
    // single octet: odd count
    payload_q.delete();
    payload_q = {payload_q, 8'h5A};
    send_payload(1'b0);
    // payload ending on a high surrogate
    payload_q.delete();
    add_unit(16'h0041);
    add_unit(16'hD800);
    send_payload(1'b0);
    // high followed by another high
    payload_q.delete();
    add_unit(16'hD800);
    add_unit(16'hDBFF);
    send_payload(1'b0);
    // low surrogate alone
    payload_q.delete();
    add_unit(16'hDC00);
    send_payload(1'b0);
    // lone low then a stray octet: odd count wins over the latched fault
    payload_q.delete();
    add_unit(16'hDFFF);
    payload_q = {payload_q, 8'hA5};
    send_payload(1'b0);

    // random phases, alternating unit order; the third one opens with a
    // long steady payload while the receiver holds off
    for (int phase = 0; phase < 4; phase++) begin
      write_endian(1'(phase % 2));
      if (phase == 2) begin
        hold_off_req = 1'b1;
        payload_q.delete();
        repeat (30) add_unit(pick_unit(U_THREE));
        send_payload(1'b1);
      end
      phase_octets = 0;
      while (phase_octets < PHASE_OCTETS) begin
        build_random_payload();
        phase_octets += payload_q.size();
        send_payload($urandom_range(0, 3) == 0);
      end
    end

    wait_quiet();
    $display("covered %0d payloads, %0d input beats, %0d endian settings and one hold-off",
             payload_count, octet_count, setting_count);
    $display("compared %0d text beats and %0d error status beats", text_beats, status_beats);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/utf16u8_pkg.sv
rtl/utf16u8_front.sv
rtl/utf16u8_queue.sv
rtl/utf16u8_back.sv
rtl/utf16_to_utf8_transcoder_unit.sv
rtl/utf16u8_checker.sv
verif/utf16_to_utf8_transcoder_checker.sv
verif/utf16_to_utf8_transcoder_unit_test.sv
